@@ hw/rtl/fcdm_pkg.sv @@
package fcdm_pkg;

   localparam int DATA_W = 32;
   localparam int RUN_W  = 8;

   localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;
   localparam logic [RUN_W-1:0] RUN_ONE = 8'd1;

   typedef enum logic [1:0] {
      OP_SUBMIT_LOCAL  = 2'd0,
      OP_SUBMIT_REMOTE = 2'd1,
      OP_TRUNCATE      = 2'd2,
      OP_CLEAR         = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   // one history slot as held in memory
   typedef struct packed {
      logic [DATA_W-1:0] frame;
      logic [DATA_W-1:0] sum;
   } entry_type;

   // commands from the sequencer to one history ring
   typedef struct packed {
      logic start;   // begin a newest-to-oldest scan
      logic trunc;   // scan looks for first frame not above the key
      logic store;   // write back checksum / append after a scan
      logic cut;     // apply truncation found by the scan
      logic clear;   // empty the ring
   } ring_cmd_type;

   typedef struct packed {
      logic busy;
      logic hit;
   } ring_stat_type;

endpackage

@@ hw/rtl/fcdm_if.sv @@
interface fcdm_req_if
   import fcdm_pkg::*;
   ;
   logic              valid;
   logic              ready;
   opcode_type        opcode;
   logic [DATA_W-1:0] frame;
   logic [DATA_W-1:0] checksum;

   modport source (output valid, output opcode, output frame, output checksum, input ready);
   modport sink   (input valid, input opcode, input frame, input checksum, output ready);
endinterface

interface fcdm_rsp_if
   import fcdm_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] frame_out;
   logic              compared;
   logic              mismatch_detected;
   logic              mismatch_resolved;
   logic [RUN_W-1:0]  run_count;

   modport source (output valid, output frame_out, output compared, output mismatch_detected,
                   output mismatch_resolved, output run_count, input ready);
   modport sink   (input valid, input frame_out, input compared, input mismatch_detected,
                   input mismatch_resolved, input run_count, output ready);
endinterface

@@ hw/rtl/frame_checksum_desync_monitor_top.sv @@
// Compares per-frame state checksums from a local and a remote source and tracks
// runs of mismatches. Each history is a ring of HISTORY_DEPTH (frame, checksum)
// pairs in its own single-port-read memory; the oldest pair is dropped when a full
// ring takes a new frame. Items are handled one at a time: a submit or truncate
// reads its ring(s) one entry per cycle, newest first; a truncate reads only the
// local ring, and a clear reads neither. A new request is taken while the previous
// result still waits in the output register. Memory contents are not cleared at
// reset; only entries inside a ring's count are ever read.
module frame_checksum_desync_monitor_top
   import fcdm_pkg::*;
#(
   parameter int HISTORY_DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   fcdm_req_if.sink  req_ch,
   fcdm_rsp_if.source rsp_ch
);

   state_type         state_ff, state_in;
   opcode_type        op_ff;
   logic [DATA_W-1:0] frame_ff;
   logic [DATA_W-1:0] sum_ff;
   logic [DATA_W-1:0] last_mm_ff, last_mm_in;
   logic [RUN_W-1:0]  run_ff, run_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic              rsp_cmp_ff, rsp_cmp_in;
   logic              rsp_mm_ff, rsp_mm_in;
   logic              rsp_res_ff, rsp_res_in;
   logic [RUN_W-1:0]  rsp_run_ff, rsp_run_in;

   ring_cmd_type      lcmd, rcmd;
   ring_stat_type     lstat, rstat;
   logic [DATA_W-1:0] lsum, rsum;

   logic              accept, out_free, rsp_load, is_submit;
   logic              other_hit, compared, mismatch, cont;
   logic [DATA_W-1:0] other_sum;
   logic [RUN_W-1:0]  run_inc, run_new;

   fcdm_ring #(.DEPTH(HISTORY_DEPTH)) u_local (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lcmd),
      .key       (frame_ff),
      .store_sum (sum_ff),
      .stat      (lstat),
      .hit_sum   (lsum)
   );

   fcdm_ring #(.DEPTH(HISTORY_DEPTH)) u_remote (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rcmd),
      .key       (frame_ff),
      .store_sum (sum_ff),
      .stat      (rstat),
      .hit_sum   (rsum)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // evaluation: own checksum is the one just stored, other comes from the scan
   always_comb begin
      is_submit = (op_ff == OP_SUBMIT_LOCAL) || (op_ff == OP_SUBMIT_REMOTE);
      other_hit = (op_ff == OP_SUBMIT_LOCAL) ? rstat.hit : lstat.hit;
      other_sum = (op_ff == OP_SUBMIT_LOCAL) ? rsum : lsum;
      compared  = is_submit && other_hit && (sum_ff != '0) && (other_sum != '0);
      mismatch  = compared && (sum_ff != other_sum);
      cont      = (last_mm_ff != '0) && (frame_ff >= last_mm_ff);
      run_inc   = (run_ff == RUN_MAX) ? RUN_MAX : (run_ff + RUN_ONE);
      run_new   = cont ? run_inc : RUN_ONE;
   end

   always_comb begin
      state_in     = state_ff;
      lcmd         = '0;
      rcmd         = '0;
      rsp_load     = 1'b0;
      last_mm_in   = last_mm_ff;
      run_in       = run_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_mm_in    = rsp_mm_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_run_in   = rsp_run_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (op_ff)
               OP_SUBMIT_LOCAL, OP_SUBMIT_REMOTE: begin
                  lcmd.start = 1'b1;
                  rcmd.start = 1'b1;
                  state_in   = ST_SCAN;
               end
               OP_TRUNCATE: begin
                  lcmd.start = 1'b1;
                  lcmd.trunc = 1'b1;
                  state_in   = ST_SCAN;
               end
               default: begin
                  state_in = ST_UPDATE;
               end
            endcase
         end
         ST_SCAN: begin
            if (!lstat.busy && !rstat.busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_load     = 1'b1;
               rsp_frame_in = is_submit ? frame_ff : '0;
               rsp_cmp_in   = compared;
               rsp_mm_in    = mismatch;
               rsp_res_in   = compared && !mismatch && ((last_mm_ff != '0) || (run_ff != '0));
               rsp_run_in   = mismatch ? run_new : '0;
               case (op_ff)
                  OP_SUBMIT_LOCAL: begin
                     lcmd.store = 1'b1;
                  end
                  OP_SUBMIT_REMOTE: begin
                     rcmd.store = 1'b1;
                  end
                  OP_TRUNCATE: begin
                     lcmd.cut = 1'b1;
                  end
                  default: begin
                     lcmd.clear = 1'b1;
                     rcmd.clear = 1'b1;
                  end
               endcase
               if (op_ff == OP_CLEAR) begin
                  last_mm_in = '0;
                  run_in     = '0;
               end else if (mismatch) begin
                  last_mm_in = frame_ff;
                  run_in     = run_new;
               end else if (compared) begin
                  last_mm_in = '0;
                  run_in     = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_mm_ff   <= '0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_mm_ff   <= last_mm_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_ch.opcode;
         frame_ff <= req_ch.frame;
         sum_ff   <= req_ch.checksum;
      end
      rsp_frame_ff <= rsp_frame_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_mm_ff    <= rsp_mm_in;
      rsp_res_ff   <= rsp_res_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.frame_out         = rsp_frame_ff;
   assign rsp_ch.compared          = rsp_cmp_ff;
   assign rsp_ch.mismatch_detected = rsp_mm_ff;
   assign rsp_ch.mismatch_resolved = rsp_res_ff;
   assign rsp_ch.run_count         = rsp_run_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_START))
      else $error("transfer did not start a sequence");

   a_scan_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (!lstat.busy && !rstat.busy))
      else $error("update while a ring scan is still running");

   a_flags_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((!rsp_mm_ff || rsp_cmp_ff) && (!rsp_res_ff || (rsp_cmp_ff && !rsp_mm_ff))))
      else $error("result flags inconsistent");

   a_run_on_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_run_ff != '0) == rsp_mm_ff))
      else $error("run count does not follow mismatch");

   a_run_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && mismatch) |=> (run_ff != '0))
      else $error("mismatch left an empty run");
`endif

endmodule

@@ hw/rtl/fcdm_ram.sv @@
module fcdm_ram
   import fcdm_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  entry_type                wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output entry_type                rdata
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

@@ hw/rtl/fcdm_ring.sv @@
module fcdm_ring
   import fcdm_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ring_cmd_type      cmd,
   input  logic [DATA_W-1:0] key,
   input  logic [DATA_W-1:0] store_sum,
   output ring_stat_type     stat,
   output logic [DATA_W-1:0] hit_sum
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL    = CW'(DEPTH);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     iss_left_ff, iss_left_in;
   logic [AW-1:0]     iss_addr_ff, iss_addr_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [AW-1:0]     rd_addr_ff, rd_addr_in;
   logic [AW-1:0]     rd_idx_ff, rd_idx_in;
   logic              hit_ff, hit_in;
   logic [AW-1:0]     hit_addr_ff, hit_addr_in;
   logic [AW-1:0]     hit_idx_ff, hit_idx_in;
   logic [DATA_W-1:0] hit_sum_ff, hit_sum_in;
   logic              trunc_ff, trunc_in;

   logic [SW-1:0] tail_sum, tail_wrap, app_sum, app_wrap;
   logic [AW-1:0] tail_addr, app_addr, head_next;
   logic          match;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata, rd_word;

   fcdm_ram #(.DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (iss_left_ff != '0),
      .raddr (iss_addr_ff),
      .rdata (rd_word)
   );

   // ring positions: sums < 2*depth when not empty, so one subtract wraps them
   always_comb begin
      tail_sum  = SW'(head_ff) + SW'(count_ff) - SW'(1);
      tail_wrap = (tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum;
      tail_addr = AW'(tail_wrap);
      app_sum   = SW'(head_ff) + SW'(count_ff);
      app_wrap  = (app_sum >= DEPTH_S) ? (app_sum - DEPTH_S) : app_sum;
      // full ring: new pair overwrites the oldest slot
      app_addr  = (count_ff == FULL) ? head_ff : AW'(app_wrap);
      head_next = (head_ff == LAST) ? '0 : (head_ff + AW'(1));
      match     = trunc_ff ? (rd_word.frame <= key) : (rd_word.frame == key);
   end

   assign mem_we          = cmd.store;
   assign mem_waddr       = hit_ff ? hit_addr_ff : app_addr;
   assign mem_wdata.frame = key;
   assign mem_wdata.sum   = store_sum;

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      iss_left_in = iss_left_ff;
      iss_addr_in = iss_addr_ff;
      rd_vld_in   = 1'b0;
      rd_addr_in  = rd_addr_ff;
      rd_idx_in   = rd_idx_ff;
      hit_in      = hit_ff;
      hit_addr_in = hit_addr_ff;
      hit_idx_in  = hit_idx_ff;
      hit_sum_in  = hit_sum_ff;
      trunc_in    = trunc_ff;

      // issue one read a cycle, newest entry first
      if (iss_left_ff != '0) begin
         rd_vld_in   = 1'b1;
         rd_addr_in  = iss_addr_ff;
         rd_idx_in   = AW'(iss_left_ff - CW'(1));
         iss_left_in = iss_left_ff - CW'(1);
         iss_addr_in = (iss_addr_ff == '0) ? LAST : (iss_addr_ff - AW'(1));
      end

      // keep only the first (newest) hit
      if (rd_vld_ff && !hit_ff && match) begin
         hit_in      = 1'b1;
         hit_addr_in = rd_addr_ff;
         hit_idx_in  = rd_idx_ff;
         hit_sum_in  = rd_word.sum;
      end

      if (cmd.start) begin
         iss_left_in = count_ff;
         iss_addr_in = tail_addr;
         hit_in      = 1'b0;
         trunc_in    = cmd.trunc;
      end

      if (cmd.store && !hit_ff) begin
         if (count_ff == FULL) begin
            head_in = head_next;
         end else begin
            count_in = count_ff + CW'(1);
         end
      end

      if (cmd.cut) begin
         count_in = hit_ff ? (CW'(hit_idx_ff) + CW'(1)) : '0;
      end

      if (cmd.clear) begin
         head_in     = '0;
         count_in    = '0;
         iss_left_in = '0;
         hit_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         count_ff    <= '0;
         iss_left_ff <= '0;
         rd_vld_ff   <= 1'b0;
         hit_ff      <= 1'b0;
         trunc_ff    <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         iss_left_ff <= iss_left_in;
         rd_vld_ff   <= rd_vld_in;
         hit_ff      <= hit_in;
         trunc_ff    <= trunc_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_addr_ff <= iss_addr_in;
      rd_addr_ff  <= rd_addr_in;
      rd_idx_ff   <= rd_idx_in;
      hit_addr_ff <= hit_addr_in;
      hit_idx_ff  <= hit_idx_in;
      hit_sum_ff  <= hit_sum_in;
   end

   assign stat.busy = (iss_left_ff != '0) || rd_vld_ff;
   assign stat.hit  = hit_ff;
   assign hit_sum   = hit_sum_ff;

endmodule
